// ===== sv/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and the control store of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int RADIX_W = 8;
  localparam int DIGIT_W = 8;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;

  typedef logic [2:0] upc_t;

  localparam upc_t S_IDLE     = 3'd0;
  localparam upc_t S_DIV_INIT = 3'd1;
  localparam upc_t S_DIV_STEP = 3'd2;
  localparam upc_t S_PUSH     = 3'd3;
  localparam upc_t S_POP_RD   = 3'd4;
  localparam upc_t S_POP_OUT  = 3'd5;
  localparam upc_t S_END      = 3'd6;
  localparam upc_t S_SPARE    = 3'd7;

  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_GOTO     = 3'd1,
    C_IN_WAIT  = 3'd2,
    C_DIV_BUSY = 3'd3,
    C_MORE     = 3'd4,
    C_OUT_BUSY = 3'd5,
    C_DEPTH    = 3'd6
  } cond_t;

  typedef struct packed {
    logic in_rdy;
    logic ld_q;
    logic div_init;
    logic div_step;
    logic push;
    logic pop_rd;
    logic out_ld;
  } uop_t;

  typedef struct packed {
    cond_t cond;
    upc_t  target;
    uop_t  uop;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic more;
    logic out_busy;
    logic depth_nz;
  } status_t;

  function automatic ctrl_word_t ucode_rom(input upc_t addr);
    ctrl_word_t w;
    w = '0;
    unique case (addr)
      S_IDLE: begin
        w.cond = C_IN_WAIT;  w.target = S_IDLE;
        w.uop.in_rdy = 1'b1; w.uop.ld_q = 1'b1;
      end
      S_DIV_INIT: begin
        w.cond = C_NEXT;     w.target = S_IDLE;
        w.uop.div_init = 1'b1;
      end
      S_DIV_STEP: begin
        w.cond = C_DIV_BUSY; w.target = S_DIV_STEP;
        w.uop.div_step = 1'b1;
      end
      S_PUSH: begin
        w.cond = C_MORE;     w.target = S_DIV_INIT;
        w.uop.push = 1'b1;
      end
      S_POP_RD: begin
        w.cond = C_OUT_BUSY; w.target = S_POP_RD;
        w.uop.pop_rd = 1'b1;
      end
      S_POP_OUT: begin
        w.cond = C_DEPTH;    w.target = S_POP_RD;
        w.uop.out_ld = 1'b1;
      end
      S_END: begin
        w.cond = C_GOTO;     w.target = S_IDLE;
      end
      S_SPARE: begin
        w.cond = C_GOTO;     w.target = S_IDLE;
      end
      default: begin
        w.cond = C_GOTO;     w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== sv/rdc_sequencer.sv =====
// ----------------------------------------------------------------------------
// rdc_sequencer
// Step counter over the control store, with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module rdc_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  rdc_pkg::status_t status,
  output rdc_pkg::uop_t    uop
);
  import rdc_pkg::*;

  upc_t       upc_r;
  upc_t       upc_nxt;
  ctrl_word_t cw;
  logic       taken;
  logic       hold;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    unique case (cw.cond)
      C_NEXT:     taken = 1'b0;
      C_GOTO:     taken = 1'b1;
      C_IN_WAIT:  taken = !status.in_valid;
      C_DIV_BUSY: taken = status.div_busy;
      C_MORE:     taken = status.more;
      C_OUT_BUSY: taken = status.out_busy;
      C_DEPTH:    taken = status.depth_nz;
      default:    taken = 1'b1;
    endcase
  end

  assign hold    = taken && ((cw.cond == C_IN_WAIT) || (cw.cond == C_OUT_BUSY));
  assign upc_nxt = taken ? cw.target : upc_t'(upc_r + 1'b1);

  // waiting steps keep ready but fire nothing else
  always_comb begin
    uop = cw.uop;
    if (hold) begin
      uop        = '0;
      uop.in_rdy = cw.uop.in_rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== sv/rdc_digit_stack.sv =====
// ----------------------------------------------------------------------------
// rdc_digit_stack
// Digit store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rdc_digit_stack #(
  parameter int DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  logic [rdc_pkg::DIGIT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic [rdc_pkg::DIGIT_W-1:0] rd_data
);
  import rdc_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/rdc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdc_datapath
// Radix register, bit-serial restoring divider, depth counter and output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic [VALUE_BITS-1:0]       in_value,
  input  rdc_pkg::uop_t               uop,
  output rdc_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rdc_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_last_digit
);
  import rdc_pkg::*;

  localparam int DEPTH_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W   = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    base_r;
  logic [VALUE_BITS-1:0] q_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [CNT_W-1:0]      bitcnt_r;
  logic [DEPTH_W-1:0]    depth_r;
  logic [DEPTH_W-1:0]    depth_inc;
  logic [DEPTH_W-1:0]    depth_dec;
  logic                  out_valid_r;
  logic [DIGIT_W-1:0]    out_digit_r;
  logic                  out_last_r;
  logic [RADIX_W:0]      shifted;
  logic [RADIX_W:0]      diff;
  logic                  ge;
  logic [RADIX_W-1:0]    rem_nxt;
  logic [DIGIT_W-1:0]    rd_data;

  assign depth_inc = depth_r + 1'b1;
  assign depth_dec = depth_r - 1'b1;

  // one quotient bit per step
  assign shifted = {rem_r, q_r[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, base_r};
  assign ge      = shifted >= {1'b0, base_r};
  assign rem_nxt = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r     <= '0;
      depth_r <= '0;
    end else begin
      if (uop.ld_q && in_valid) begin
        q_r     <= in_value;
        depth_r <= '0;
      end else if (uop.div_step) begin
        q_r <= {q_r[VALUE_BITS-2:0], ge};
      end
      if (uop.push) begin
        depth_r <= depth_inc;
      end else if (uop.pop_rd) begin
        depth_r <= depth_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uop.ld_q && in_valid) begin
      base_r <= (radix_r < RADIX_MIN) ? RADIX_MIN : radix_r;
    end
    if (uop.div_init) begin
      rem_r    <= '0;
      bitcnt_r <= CNT_W'(VALUE_BITS - 1);
    end else if (uop.div_step) begin
      rem_r    <= rem_nxt;
      bitcnt_r <= bitcnt_r - 1'b1;
    end
  end

  rdc_digit_stack #(
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (uop.push),
    .wr_addr (depth_r[IDX_W-1:0]),
    .wr_data (rem_r),
    .rd_en   (uop.pop_rd),
    .rd_addr (depth_dec[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uop.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uop.out_ld) begin
      out_digit_r <= rd_data;
      out_last_r  <= (depth_r == '0);
    end
  end

  assign status.in_valid = in_valid;
  assign status.div_busy = (bitcnt_r != '0);
  assign status.more     = (q_r != '0) && (depth_inc < DEPTH_W'(MAX_DIGITS));
  assign status.out_busy = out_valid_r && !out_ready;
  assign status.depth_nz = (depth_r != '0);

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

endmodule

// ===== sv/radix_digit_converter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned integer to digits in the configured base, most
// significant digit first, flagging the final digit.
// ----------------------------------------------------------------------------
// a new value is accepted only in the idle step, once every digit of the previous
// value has been loaded for output; a digit is read from the store only while the
// output is not stalled by out_ready; the restoring divider makes one bit per cycle
// reset: synchronous, active low; radix returns to 10, sequencer to its idle step
// the digit store is not cleared
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [VALUE_BITS-1:0]       in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rdc_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_last_digit
);
  import rdc_pkg::*;

  uop_t    uop;
  status_t status;

  rdc_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .uop    (uop)
  );

  rdc_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_value       (in_value),
    .uop            (uop),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit)
  );

  assign in_ready = uop.in_rdy;

endmodule

// ===== sim/radix_digit_converter_test.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_test
// Sends integers to the converter under a range of radix settings and checks
// every digit and final-digit flag against a built-in conversion model. Both
// handshakes idle at random; the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module radix_digit_converter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;

  localparam int VALUE_BITS  = 31;
  localparam int MAX_DIGITS  = 32;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_GAP  = 4;
  localparam int DRAIN_GAP   = 1200;
  localparam int HOLD_CYCLES = 600;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_flag;
  } digit_exp_t;

  class digit_scoreboard;
    logic [RADIX_W-1:0] radix;
    digit_exp_t         expected_digits[$];
    int                 errors;
    int                 requests;
    int                 digits_checked;

    function new();
      radix          = RADIX_RESET;
      errors         = 0;
      requests       = 0;
      digits_checked = 0;
    endfunction

    function void set_radix(input logic [RADIX_W-1:0] r);
      radix = r;
    endfunction

    function void note_value(input logic [VALUE_BITS-1:0] v);
      logic [DIGIT_W-1:0]    rev[MAX_DIGITS];
      logic [VALUE_BITS-1:0] q;
      logic [VALUE_BITS-1:0] base;
      int                    n;
      // bases below two behave as binary
      base = (radix < RADIX_MIN) ? VALUE_BITS'(RADIX_MIN) : VALUE_BITS'(radix);
      q = v;
      n = 0;
      requests++;
      if (q == '0) begin
        rev[0] = '0;
        n = 1;
      end
      while (q != '0 && n < MAX_DIGITS) begin
        rev[n] = DIGIT_W'(q % base);
        q = q / base;
        n++;
      end
      for (int i = n - 1; i >= 0; i--) begin
        expected_digits.push_back('{digit: rev[i], last_flag: (i == 0)});
      end
    endfunction

    function void check_digit(input logic [DIGIT_W-1:0] digit, input logic last_flag);
      digit_exp_t e;
      if (expected_digits.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit, expected none, actual %0d last %0b",
                 $time, digit, last_flag);
        return;
      end
      e = expected_digits.pop_front();
      digits_checked++;
      if (digit !== e.digit) begin
        errors++;
        $display("%0t: digit mismatch, expected %0d, actual %0d", $time, e.digit, digit);
      end
      if (last_flag !== e.last_flag) begin
        errors++;
        $display("%0t: last_digit mismatch, expected %0b, actual %0b",
                 $time, e.last_flag, last_flag);
      end
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0]    cfg_wr_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DIGIT_W-1:0]    out_digit;
  logic                  out_last_digit;

  digit_scoreboard sb = new();
  int send_idle_pct = 25;
  int recv_idle_pct = 86;
  int hold_left = 0;
  int cycles = 0;
  int radix_writes = 0;

  radix_digit_converter #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit     (out_digit),
    .out_last_digit(out_last_digit)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycles, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        sb.set_radix(cfg_wr_data);
      end
      if (in_valid && in_ready) begin
        sb.note_value(in_value);
      end
      if (out_valid && out_ready) begin
        sb.check_digit(out_digit, out_last_digit);
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radix_writes++;
  endtask

  function automatic logic [VALUE_BITS-1:0] random_value();
    int w;
    w = $urandom_range(VALUE_BITS, 1);
    if ($urandom_range(31) == 0) begin
      return '0;
    end
    return VALUE_BITS'($urandom) & (VALUE_MAX >> (VALUE_BITS - w));
  endfunction

  function automatic logic [RADIX_W-1:0] random_radix();
    unique case ($urandom_range(9))
      0:       return RADIX_MIN;
      1:       return 8'd255;
      2:       return RADIX_W'($urandom_range(1, 0));
      default: return RADIX_W'($urandom_range(255, 2));
    endcase
  endfunction

  task automatic random_phase(input int sender_pct, input int receiver_pct,
                              input int count, input bit with_hold);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 15 == 0) begin
        write_radix(random_radix());
      end
      if (with_hold && i == 20) begin
        hold_left = HOLD_CYCLES;
      end
      send_value(random_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset radix of ten
    send_value('0);
    send_value(31'd1);
    send_value(31'd9);
    send_value(31'd10);
    send_value(VALUE_MAX);
    // binary, longest digit run
    write_radix(8'd2);
    send_value(VALUE_MAX);
    send_value(31'd1);
    send_value(31'h4000_0000);
    send_value('0);
    // widest base, largest digit
    write_radix(8'd255);
    send_value(31'd254);
    send_value(31'd255);
    send_value(31'd65024);
    send_value(VALUE_MAX);
    // bases below two
    write_radix(8'd0);
    send_value(31'd5);
    send_value(VALUE_MAX);
    write_radix(8'd1);
    send_value(31'd6);
    write_radix(8'd16);
    send_value(VALUE_MAX);
    send_value(31'h1234_5678);
    write_radix(8'd3);
    send_value(VALUE_MAX);
    write_radix(8'd254);
    send_value(31'd253);

    random_phase(25, 86, 54, 1'b0);
    random_phase(86, 25, 54, 1'b0);
    random_phase(0, 0, 54, 1'b1);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);

    $display("run covered %0d conversions and %0d digits over %0d radix writes",
             sb.requests, sb.digits_checked, radix_writes);
    $display("including zero values, bases below two and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d digits outstanding", sb.errors, sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rdc_pkg.sv
sv/rdc_sequencer.sv
sv/rdc_digit_stack.sv
sv/rdc_datapath.sv
sv/radix_digit_converter.sv
sim/radix_digit_converter_test.sv
